// File: hw/rtl/berk4_pkg.sv
// Shared types, constants and the step microprogram of the beta envelope RK4 block.
`timescale 1ns / 1ps
`default_nettype none
package berk4_pkg;

	// Number format and unit sizes
	localparam int WORD_W     = 48;
	localparam int FRAC_W     = 24;
	localparam int EXT_W      = WORD_W + FRAC_W;
	localparam int PROD_W     = 2 * WORD_W;
	localparam int HALF_W     = WORD_W / 2;
	localparam int BS_W       = 47;
	localparam int CFG_IDX_W  = 2;
	localparam int PC_W       = 7;
	localparam int ADDR_W     = 5;
	localparam int RF_AW      = 4;
	localparam int RF_DEPTH   = 1 << RF_AW;
	localparam int CNT_W      = 7;
	localparam int MUL_PARTS  = 4;
	localparam int DIV_STEPS  = EXT_W;
	localparam int DERIV_SKIP = 10;
	localparam int PROG_LEN   = 74;

	typedef logic signed [WORD_W-1:0] word_t;

	localparam word_t WORD_MAX = word_t'({1'b0, {(WORD_W-1){1'b1}}});
	localparam word_t WORD_MIN = word_t'({1'b1, {(WORD_W-1){1'b0}}});
	localparam word_t Q_ONE    = word_t'({1'b1, {FRAC_W{1'b0}}});
	localparam word_t Q_HALF   = word_t'({1'b1, {(FRAC_W-1){1'b0}}});

	// Divide by six as a halving, then a multiply by ceil(2^49 / 3) and a shift by 49
	localparam logic [WORD_W-1:0] DIV6_M  = 48'hAAAA_AAAA_AAAB;
	localparam int                DIV6_SH = 49;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BETA_START  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_START = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ANG_MOM     = 2'd2;

	// Arithmetic unit operations
	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_DIV6,
		OP_DCHK
	} op_t;

	typedef logic [ADDR_W-1:0] addr_t;

	// Scratch registers (memory) and special sources (flops)
	localparam addr_t A_C    = 5'd0;
	localparam addr_t A_H    = 5'd1;
	localparam addr_t A_HH   = 5'd2;
	localparam addr_t A_K1P  = 5'd3;
	localparam addr_t A_B2   = 5'd4;
	localparam addr_t A_K2B  = 5'd5;
	localparam addr_t A_K2P  = 5'd6;
	localparam addr_t A_B3   = 5'd7;
	localparam addr_t A_K3B  = 5'd8;
	localparam addr_t A_K3P  = 5'd9;
	localparam addr_t A_B4   = 5'd10;
	localparam addr_t A_K4B  = 5'd11;
	localparam addr_t A_K4P  = 5'd12;
	localparam addr_t A_T0   = 5'd13;
	localparam addr_t A_T1   = 5'd14;
	localparam addr_t A_T2   = 5'd15;
	localparam addr_t A_ONE  = 5'd16;
	localparam addr_t A_HALF = 5'd17;
	localparam addr_t A_LV   = 5'd18;
	localparam addr_t A_POS  = 5'd19;
	localparam addr_t A_PPOS = 5'd20;
	localparam addr_t A_KK   = 5'd21;
	localparam addr_t A_B    = 5'd22;
	localparam addr_t A_BP   = 5'd23;

	typedef struct packed {
		op_t   op;
		addr_t d;
		addr_t a;
		addr_t b;
	} instr_t;

	typedef struct packed {
		logic  start;
		op_t   op;
		word_t a;
		word_t b;
	} alu_req_t;

	typedef struct packed {
		logic  done;
		logic  flt;
		logic  skip;
		word_t res;
	} alu_rsp_t;

	typedef struct packed {
		word_t val;
		logic  flt;
	} sat_t;

	// Restore sign on a magnitude and saturate to the word range
	function automatic sat_t from_mag(logic [EXT_W-1:0] m, logic neg);
		sat_t r;
		logic [EXT_W-1:0] lim;
		lim = EXT_W'($unsigned(WORD_MAX));
		r.flt = 1'b0;
		if (!neg) begin
			if (m > lim) begin
				r.val = WORD_MAX;
				r.flt = 1'b1;
			end else begin
				r.val = word_t'(m[WORD_W-1:0]);
			end
		end else begin
			if (m > lim + EXT_W'(1)) begin
				r.val = WORD_MIN;
				r.flt = 1'b1;
			end else begin
				r.val = word_t'(~m[WORD_W-1:0] + WORD_W'(1));
			end
		end
		return r;
	endfunction

	function automatic instr_t mk(op_t op, addr_t d, addr_t a, addr_t b);
		instr_t r;
		r.op = op;
		r.d  = d;
		r.a  = a;
		r.b  = b;
		return r;
	endfunction

	// Slope derivative: check beta, then (bp^2 + c - 4 (b k)^2) / (2 b)
	function automatic instr_t deriv_ins(logic [3:0] k, addr_t b, addr_t bp, addr_t dst);
		instr_t r;
		case (k)
			4'd0: r = mk(OP_DCHK, dst, b, b);
			4'd1: r = mk(OP_MUL, A_T0, b, A_KK);
			4'd2: r = mk(OP_MUL, A_T1, bp, bp);
			4'd3: r = mk(OP_ADD, A_T1, A_T1, A_C);
			4'd4: r = mk(OP_MUL, A_T0, A_T0, A_T0);
			4'd5: r = mk(OP_ADD, A_T0, A_T0, A_T0);
			4'd6: r = mk(OP_ADD, A_T0, A_T0, A_T0);
			4'd7: r = mk(OP_SUB, A_T0, A_T1, A_T0);
			4'd8: r = mk(OP_ADD, A_T2, b, b);
			4'd9: r = mk(OP_DIV, dst, A_T0, A_T2);
			default: r = mk(OP_ADD, A_T0, A_T0, A_T0);
		endcase
		return r;
	endfunction

	// Microprogram of one RK4 step
	function automatic instr_t prog_rom(logic [PC_W-1:0] pc);
		instr_t r;
		if (pc >= 7'd6 && pc <= 7'd15) begin
			r = deriv_ins(4'(pc - 7'd6), A_B, A_BP, A_K1P);
		end else if (pc >= 7'd20 && pc <= 7'd29) begin
			r = deriv_ins(4'(pc - 7'd20), A_B2, A_K2B, A_K2P);
		end else if (pc >= 7'd34 && pc <= 7'd43) begin
			r = deriv_ins(4'(pc - 7'd34), A_B3, A_K3B, A_K3P);
		end else if (pc >= 7'd48 && pc <= 7'd57) begin
			r = deriv_ins(4'(pc - 7'd48), A_B4, A_K4B, A_K4P);
		end else begin
			case (pc)
				7'd0:  r = mk(OP_MUL, A_C, A_LV, A_LV);
				7'd1:  r = mk(OP_ADD, A_C, A_ONE, A_C);
				7'd2:  r = mk(OP_ADD, A_C, A_C, A_C);
				7'd3:  r = mk(OP_ADD, A_C, A_C, A_C);
				7'd4:  r = mk(OP_SUB, A_H, A_POS, A_PPOS);
				7'd5:  r = mk(OP_MUL, A_HH, A_H, A_HALF);
				7'd16: r = mk(OP_MUL, A_T0, A_HH, A_BP);
				7'd17: r = mk(OP_ADD, A_B2, A_B, A_T0);
				7'd18: r = mk(OP_MUL, A_T0, A_HH, A_K1P);
				7'd19: r = mk(OP_ADD, A_K2B, A_BP, A_T0);
				7'd30: r = mk(OP_MUL, A_T0, A_HH, A_K2B);
				7'd31: r = mk(OP_ADD, A_B3, A_B, A_T0);
				7'd32: r = mk(OP_MUL, A_T0, A_HH, A_K2P);
				7'd33: r = mk(OP_ADD, A_K3B, A_BP, A_T0);
				7'd44: r = mk(OP_MUL, A_T0, A_H, A_K3B);
				7'd45: r = mk(OP_ADD, A_B4, A_B, A_T0);
				7'd46: r = mk(OP_MUL, A_T0, A_H, A_K3P);
				7'd47: r = mk(OP_ADD, A_K4B, A_BP, A_T0);
				7'd58: r = mk(OP_ADD, A_T0, A_K2B, A_K2B);
				7'd59: r = mk(OP_ADD, A_T0, A_BP, A_T0);
				7'd60: r = mk(OP_ADD, A_T1, A_K3B, A_K3B);
				7'd61: r = mk(OP_ADD, A_T1, A_T1, A_K4B);
				7'd62: r = mk(OP_ADD, A_T0, A_T0, A_T1);
				7'd63: r = mk(OP_MUL, A_T0, A_H, A_T0);
				7'd64: r = mk(OP_DIV6, A_T0, A_T0, A_T0);
				7'd65: r = mk(OP_ADD, A_B, A_B, A_T0);
				7'd66: r = mk(OP_ADD, A_T0, A_K2P, A_K2P);
				7'd67: r = mk(OP_ADD, A_T0, A_K1P, A_T0);
				7'd68: r = mk(OP_ADD, A_T1, A_K3P, A_K3P);
				7'd69: r = mk(OP_ADD, A_T1, A_T1, A_K4P);
				7'd70: r = mk(OP_ADD, A_T0, A_T0, A_T1);
				7'd71: r = mk(OP_MUL, A_T0, A_H, A_T0);
				7'd72: r = mk(OP_DIV6, A_T0, A_T0, A_T0);
				7'd73: r = mk(OP_ADD, A_BP, A_BP, A_T0);
				default: r = mk(OP_ADD, A_T0, A_T0, A_T0);
			endcase
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/berk4_alu.sv
// Shared saturating arithmetic unit: add, subtract, 4-part multiply, divide by six, bit-serial divide, beta check.
`timescale 1ns / 1ps
`default_nettype none
module berk4_alu (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire berk4_pkg::alu_req_t req,
	output berk4_pkg::alu_rsp_t     rsp
);
	import berk4_pkg::*;

	typedef enum logic [4:0] {
		A_IDLE   = 5'b00001,
		A_SIMPLE = 5'b00010,
		A_MUL    = 5'b00100,
		A_DIV    = 5'b01000,
		A_FIN    = 5'b10000
	} alu_state_t;

	alu_state_t state_q;
	op_t        op_q;
	word_t      a_q;
	word_t      b_q;
	logic       neg_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PROD_W-1:0] acc_q;
	logic [WORD_W-1:0] pp_s1;
	logic [1:0]        pp_sh_s1;
	logic              pp_vld_s1;
	logic [EXT_W-1:0]  dvd_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] dvs_q;

	function automatic logic [WORD_W-1:0] mag(word_t x);
		logic [WORD_W-1:0] u;
		u = $unsigned(x);
		return u[WORD_W-1] ? (~u + WORD_W'(1)) : u;
	endfunction

	function automatic sat_t sat_add(word_t x, word_t y);
		sat_t r;
		logic [WORD_W:0] s;
		s = {x[WORD_W-1], x} + {y[WORD_W-1], y};
		r.flt = 1'b0;
		r.val = word_t'(s[WORD_W-1:0]);
		if (s[WORD_W] != s[WORD_W-1]) begin
			r.flt = 1'b1;
			r.val = s[WORD_W] ? WORD_MIN : WORD_MAX;
		end
		return r;
	endfunction

	// Partial product operands and shifted partial product
	logic [HALF_W-1:0] ha, hb;
	logic [PROD_W-1:0] pp_ext;
	assign ha = cnt_q[1] ? a_q[WORD_W-1:HALF_W] : a_q[HALF_W-1:0];
	assign hb = cnt_q[0] ? b_q[WORD_W-1:HALF_W] : b_q[HALF_W-1:0];

	always_comb begin
		case (pp_sh_s1)
			2'd0:    pp_ext = PROD_W'(pp_s1);
			2'd1:    pp_ext = PROD_W'(pp_s1) << HALF_W;
			2'd2:    pp_ext = PROD_W'(pp_s1) << WORD_W;
			default: pp_ext = '0;
		endcase
	end

	// Restoring divide step
	logic [WORD_W-1:0] remsh;
	logic              ge;
	assign remsh = {rem_q[WORD_W-2:0], dvd_q[EXT_W-1]};
	assign ge    = remsh >= dvs_q;

	// Sequence the unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= A_IDLE;
			pp_vld_s1 <= 1'b0;
			cnt_q     <= '0;
		end else begin
			case (state_q)
				A_IDLE: begin
					if (req.start) begin
						cnt_q     <= '0;
						pp_vld_s1 <= 1'b0;
						case (req.op)
							OP_MUL, OP_DIV6: state_q <= A_MUL;
							OP_DIV:          state_q <= A_DIV;
							default:         state_q <= A_SIMPLE;
						endcase
					end
				end
				A_SIMPLE: state_q <= A_IDLE;
				A_MUL: begin
					cnt_q     <= cnt_q + CNT_W'(1);
					pp_vld_s1 <= cnt_q < CNT_W'(MUL_PARTS);
					if (cnt_q == CNT_W'(MUL_PARTS)) begin
						state_q <= A_FIN;
					end
				end
				A_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= A_FIN;
					end
				end
				A_FIN: state_q <= A_IDLE;
				default: state_q <= A_IDLE;
			endcase
		end
	end

	// Operand, accumulator and divider datapath
	always_ff @(posedge clk) begin
		if (state_q == A_IDLE && req.start) begin
			op_q <= req.op;
			case (req.op)
				OP_MUL: begin
					a_q   <= word_t'(mag(req.a));
					b_q   <= word_t'(mag(req.b));
					neg_q <= req.a[WORD_W-1] ^ req.b[WORD_W-1];
					acc_q <= PROD_W'($unsigned(Q_HALF));
				end
				OP_DIV: begin
					neg_q <= req.a[WORD_W-1];
					dvd_q <= {mag(req.a), {FRAC_W{1'b0}}};
					dvs_q <= $unsigned(req.b);
					rem_q <= '0;
				end
				OP_DIV6: begin
					// halve the rounded magnitude, then multiply by the reciprocal of three
					a_q   <= word_t'((mag(req.a) + WORD_W'(3)) >> 1);
					b_q   <= word_t'(DIV6_M);
					neg_q <= req.a[WORD_W-1];
					acc_q <= '0;
				end
				default: begin
					a_q <= req.a;
					b_q <= req.b;
				end
			endcase
		end
		if (state_q == A_MUL) begin
			pp_s1    <= WORD_W'(ha) * WORD_W'(hb);
			pp_sh_s1 <= 2'(cnt_q[1]) + 2'(cnt_q[0]);
			if (pp_vld_s1) begin
				acc_q <= acc_q + pp_ext;
			end
		end
		if (state_q == A_DIV) begin
			rem_q <= ge ? remsh - dvs_q : remsh;
			dvd_q <= {dvd_q[EXT_W-2:0], ge};
		end
	end

	// Form the result
	sat_t             simple_r;
	sat_t             fin_r;
	word_t            neg_b;
	logic             neg_flt;
	logic             rnd;
	logic             nonpos;
	always_comb begin
		neg_flt = 1'b0;
		neg_b   = b_q;
		if (op_q == OP_SUB) begin
			if (b_q == WORD_MIN) begin
				neg_b   = WORD_MAX;
				neg_flt = 1'b1;
			end else begin
				neg_b = -b_q;
			end
		end
		simple_r = sat_add(a_q, neg_b);
		simple_r.flt = simple_r.flt | neg_flt;
		nonpos = a_q[WORD_W-1] || (a_q == '0);
		rnd    = {rem_q, 1'b0} >= {1'b0, dvs_q};
		if (op_q == OP_MUL) begin
			fin_r = from_mag(acc_q[PROD_W-1:FRAC_W], neg_q);
		end else if (op_q == OP_DIV6) begin
			fin_r = from_mag(EXT_W'(acc_q[PROD_W-1:DIV6_SH]), neg_q);
		end else begin
			fin_r = from_mag(dvd_q + EXT_W'(rnd), neg_q);
		end

		rsp.done = (state_q == A_SIMPLE) || (state_q == A_FIN);
		rsp.skip = 1'b0;
		rsp.flt  = 1'b0;
		rsp.res  = '0;
		if (state_q == A_FIN) begin
			rsp.res = fin_r.val;
			rsp.flt = fin_r.flt;
		end else if (op_q == OP_DCHK) begin
			rsp.skip = nonpos;
			rsp.flt  = nonpos;
		end else begin
			rsp.res = simple_r.val;
			rsp.flt = simple_r.flt;
		end
	end

	// A result is a single-cycle pulse
	assert property (@(posedge clk) disable iff (!arst_n) rsp.done |=> !rsp.done)
		else $error("alu done held for more than one cycle");
	// Work is only started on an idle unit
	assert property (@(posedge clk) disable iff (!arst_n) req.start |-> state_q == A_IDLE)
		else $error("alu started while busy");
	// A multiply ends with its last partial product accumulated
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == A_MUL && cnt_q == CNT_W'(MUL_PARTS)) |-> pp_vld_s1)
		else $error("multiply finished without last partial product");

endmodule
`default_nettype wire

// File: hw/rtl/beta_envelope_rk4_step.sv
// Top level: RK4 step sequencer for the beta envelope equation around a shared arithmetic unit.
//
//  channel | signals                                | direction
//  --------+----------------------------------------+----------
//  cfg     | cfg_we, cfg_index, cfg_data            | in
//  in      | in_valid, in_stall, start_req,         | in
//          | position, focusing                     |
//  out     | out_valid, out_stall, beta,            | out
//          | beta_slope, fault                      |
//
// A step sample runs a 74-instruction microprogram through one shared unit: four 72-step
// bit-serial divisions, 24 multiplies of four 24x24 partial products (two of them divide by
// six through a reciprocal) and 46 adds and checks. A failed beta check skips the rest of
// that derivative. Reset clears the state to zero and the registers to beta_start = 1.0.
// in_stall is high from acceptance until the result is loaded into the output register;
// a stalled result holds the next one in the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module beta_envelope_rk4_step (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [berk4_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [berk4_pkg::WORD_W-1:0]       cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic                               start_req,
	input  wire berk4_pkg::word_t                   position,
	input  wire berk4_pkg::word_t                   focusing,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output berk4_pkg::word_t                        beta,
	output berk4_pkg::word_t                        beta_slope,
	output logic                                    fault
);
	import berk4_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_EXEC = 4'b0100,
		ST_DONE = 4'b1000
	} seq_state_t;

	seq_state_t state_q;
	logic [PC_W-1:0] pc_q;
	logic            go_q;
	logic            fault_q;
	logic [BS_W-1:0] beta_start_q;
	word_t           slope_start_q;
	word_t           ang_mom_q;
	word_t           pos_q;
	word_t           foc_q;
	word_t           prev_position_q;
	word_t           prev_focusing_q;
	word_t           beta_now_q;
	word_t           slope_now_q;
	word_t           rd_a_q;
	word_t           rd_b_q;
	logic            out_valid_q;
	word_t           beta_q;
	word_t           slope_q;
	logic            out_fault_q;
	word_t           rf_mem [RF_DEPTH];

	instr_t   ins;
	alu_req_t alu_req;
	alu_rsp_t alu_rsp;
	logic     in_acc;
	logic     out_free;
	logic     wr_en;
	logic     rf_we;

	assign ins      = prog_rom(pc_q);
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign wr_en    = alu_rsp.done && ((ins.op != OP_DCHK) || alu_rsp.skip);
	assign rf_we    = wr_en && !ins.d[ADDR_W-1];

	assign out_valid  = out_valid_q;
	assign beta       = beta_q;
	assign beta_slope = slope_q;
	assign fault      = out_fault_q;

	// Select an operand from a special source or the scratch read
	function automatic word_t pick(addr_t a, word_t rd, word_t lv, word_t pos,
		word_t ppos, word_t kk, word_t b, word_t bp);
		word_t r;
		case (a)
			A_ONE:   r = Q_ONE;
			A_HALF:  r = Q_HALF;
			A_LV:    r = lv;
			A_POS:   r = pos;
			A_PPOS:  r = ppos;
			A_KK:    r = kk;
			A_B:     r = b;
			A_BP:    r = bp;
			default: r = rd;
		endcase
		return r;
	endfunction

	always_comb begin
		alu_req.start = go_q;
		alu_req.op    = ins.op;
		alu_req.a     = pick(ins.a, rd_a_q, ang_mom_q, pos_q, prev_position_q,
			prev_focusing_q, beta_now_q, slope_now_q);
		alu_req.b     = pick(ins.b, rd_b_q, ang_mom_q, pos_q, prev_position_q,
			prev_focusing_q, beta_now_q, slope_now_q);
	end

	berk4_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	// Scratch memory: one write, two registered reads
	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_mem[ins.d[RF_AW-1:0]] <= alu_rsp.res;
		end
		if (state_q == ST_READ) begin
			rd_a_q <= rf_mem[ins.a[RF_AW-1:0]];
			rd_b_q <= rf_mem[ins.b[RF_AW-1:0]];
		end
	end

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_start_q  <= BS_W'($unsigned(Q_ONE));
			slope_start_q <= '0;
			ang_mom_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BETA_START:  beta_start_q  <= cfg_data[BS_W-1:0];
				CFG_SLOPE_START: slope_start_q <= word_t'(cfg_data);
				CFG_ANG_MOM:     ang_mom_q     <= word_t'(cfg_data);
				default: ;
			endcase
		end
	end

	// Sequence the step and hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			pc_q            <= '0;
			go_q            <= 1'b0;
			fault_q         <= 1'b0;
			prev_position_q <= '0;
			prev_focusing_q <= '0;
			beta_now_q      <= '0;
			slope_now_q     <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			go_q <= (state_q == ST_READ);
			// Present a finished step, or drop a taken result
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						fault_q <= 1'b0;
						pc_q    <= '0;
						if (start_req) begin
							beta_now_q  <= word_t'({1'b0, beta_start_q});
							slope_now_q <= slope_start_q;
							state_q     <= ST_DONE;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (alu_rsp.done) begin
						fault_q <= fault_q | alu_rsp.flt;
						if (wr_en && ins.d == A_B) begin
							beta_now_q <= alu_rsp.res;
						end
						if (wr_en && ins.d == A_BP) begin
							slope_now_q <= alu_rsp.res;
						end
						if (pc_q == PC_W'(PROG_LEN - 1)) begin
							state_q <= ST_DONE;
						end else begin
							pc_q    <= alu_rsp.skip ? pc_q + PC_W'(DERIV_SKIP)
								: pc_q + PC_W'(1);
							state_q <= ST_READ;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						prev_position_q <= pos_q;
						prev_focusing_q <= foc_q;
						state_q         <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Latch the sample and load the output register
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pos_q <= position;
			foc_q <= focusing;
		end
		if (state_q == ST_DONE && out_free) begin
			beta_q      <= beta_now_q;
			slope_q     <= slope_now_q;
			out_fault_q <= fault_q;
		end
	end

	// Results come back only to a waiting sequencer
	assert property (@(posedge clk) disable iff (!arst_n) alu_rsp.done |-> state_q == ST_EXEC)
		else $error("arithmetic result outside execute");
	// The program counter stays inside the microprogram
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> pc_q < PC_W'(PROG_LEN))
		else $error("program counter out of range");
	// A finished step is presented on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> out_valid)
		else $error("finished step not presented");
	// No new sample is taken while a step is in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ || state_q == ST_EXEC) |-> in_stall)
		else $error("input open during a step");

endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the beta envelope RK4 step block.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import berk4_pkg::*;

	localparam longint QMAX = 64'sh7FFF_FFFF_FFFF;
	localparam longint QMIN = -QMAX - 1;
	localparam longint QONE = 64'sd16777216;
	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE = 40;

	typedef struct {
		longint b;
		longint bp;
		bit flt;
	} envelope_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic start_req;
	word_t position;
	word_t focusing;
	logic out_valid;
	logic out_stall;
	word_t beta;
	word_t beta_slope;
	logic fault;

	beta_envelope_rk4_step dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.start_req(start_req), .position(position), .focusing(focusing),
		.out_valid(out_valid), .out_stall(out_stall), .beta(beta),
		.beta_slope(beta_slope), .fault(fault)
	);

	// Predictor state and register copies
	longint beta_start_r, slope_start_r, ang_mom_r;
	longint last_pos, last_foc, beta_cur, slope_cur;
	bit sat_seen;

	envelope_t envelope_q[$];
	int errors;
	int n_starts, n_steps, n_faults, n_results;
	bit idle_on;
	int hold_left;
	int quiet_cycles;
	longint run_pos;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Saturate a magnitude with a sign to the word range
	function automatic longint sat_mag(logic [127:0] m, bit neg);
		if (!neg) begin
			if (m > 128'(QMAX)) begin
				sat_seen = 1'b1;
				return QMAX;
			end
			return longint'(m[63:0]);
		end
		if (m > 128'(QMAX) + 128'd1) begin
			sat_seen = 1'b1;
			return QMIN;
		end
		return -longint'(m[63:0]);
	endfunction

	function automatic logic [127:0] mag_of(longint x);
		return (x < 0) ? 128'(-x) : 128'(x);
	endfunction

	function automatic longint q_add(longint a, longint b);
		longint s;
		s = a + b;
		if (s > QMAX) begin
			sat_seen = 1'b1;
			return QMAX;
		end
		if (s < QMIN) begin
			sat_seen = 1'b1;
			return QMIN;
		end
		return s;
	endfunction

	function automatic longint q_sub(longint a, longint b);
		return q_add(a, sat_mag(mag_of(b), b > 0));
	endfunction

	function automatic longint q_twice(longint x);
		return q_add(x, x);
	endfunction

	function automatic longint q_mul(longint a, longint b);
		logic [127:0] p;
		p = mag_of(a) * mag_of(b);
		p = (p + (128'd1 << (FRAC_W - 1))) >> FRAC_W;
		return sat_mag(p, (a < 0) != (b < 0));
	endfunction

	function automatic longint q_div(longint n, longint d);
		logic [127:0] num, dd, q, r;
		num = mag_of(n) << FRAC_W;
		dd = 128'(d);
		q = num / dd;
		r = num % dd;
		if (r >= dd - r)
			q = q + 128'd1;
		return sat_mag(q, n < 0);
	endfunction

	function automatic longint q_div6(longint x);
		return sat_mag((mag_of(x) + 128'd3) / 128'd6, x < 0);
	endfunction

	// Slope derivative of the envelope equation; non-positive beta faults
	function automatic longint slope_rate(longint b, longint bp, longint kk, longint c);
		longint bk, num;
		if (b <= 0) begin
			sat_seen = 1'b1;
			return 0;
		end
		bk = q_mul(b, kk);
		num = q_sub(q_add(q_mul(bp, bp), c), q_twice(q_twice(q_mul(bk, bk))));
		return q_div(num, q_twice(b));
	endfunction

	// Advance the envelope by one sample and return the expected result
	function automatic envelope_t rk4_advance(bit s, word_t p, word_t f);
		envelope_t e;
		longint c, h, hh, kk, b, bp;
		longint k1p, k2b, k2p, k3b, k3p, k4b, k4p, b2, b3, b4, sb, sp;
		sat_seen = 1'b0;
		if (s) begin
			beta_cur = beta_start_r;
			slope_cur = slope_start_r;
		end else begin
			c = q_twice(q_twice(q_add(QONE, q_mul(ang_mom_r, ang_mom_r))));
			h = q_sub(longint'(p), last_pos);
			hh = q_mul(h, QONE / 2);
			kk = last_foc;
			b = beta_cur;
			bp = slope_cur;
			k1p = slope_rate(b, bp, kk, c);
			b2 = q_add(b, q_mul(hh, bp));
			k2b = q_add(bp, q_mul(hh, k1p));
			k2p = slope_rate(b2, k2b, kk, c);
			b3 = q_add(b, q_mul(hh, k2b));
			k3b = q_add(bp, q_mul(hh, k2p));
			k3p = slope_rate(b3, k3b, kk, c);
			b4 = q_add(b, q_mul(h, k3b));
			k4b = q_add(bp, q_mul(h, k3p));
			k4p = slope_rate(b4, k4b, kk, c);
			sb = q_add(q_add(bp, q_twice(k2b)), q_add(q_twice(k3b), k4b));
			sp = q_add(q_add(k1p, q_twice(k2p)), q_add(q_twice(k3p), k4p));
			beta_cur = q_add(b, q_div6(q_mul(h, sb)));
			slope_cur = q_add(bp, q_div6(q_mul(h, sp)));
		end
		last_pos = longint'(p);
		last_foc = longint'(f);
		e.b = beta_cur;
		e.bp = slope_cur;
		e.flt = sat_seen;
		return e;
	endfunction

	function automatic word_t rnd_word();
		return word_t'({$urandom, $urandom});
	endfunction

	// Uniform signed value in [-span, span]
	function automatic longint rnd_span(int unsigned span);
		return longint'($urandom_range(2 * span, 0)) - longint'(span);
	endfunction

	// Offer one sample, hold it until accepted, queue its prediction
	task automatic send_sample(bit s, word_t p, word_t f);
		@(negedge clk);
		while (idle_on && $urandom_range(99, 0) < 22) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		start_req <= s;
		position <= p;
		focusing <= f;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		envelope_q.push_back(rk4_advance(s, p, f));
		if (s)
			n_starts++;
		else
			n_steps++;
	endtask

	// Drop valid and wait until every expected result has come back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (envelope_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == CFG_BETA_START)
			beta_start_r = longint'(val[BS_W-1:0]);
		else if (idx == CFG_SLOPE_START)
			slope_start_r = longint'(word_t'(val));
		else if (idx == CFG_ANG_MOM)
			ang_mom_r = longint'(word_t'(val));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(longint bs, longint ss, longint am);
		drain();
		write_reg(CFG_BETA_START, WORD_W'(bs));
		write_reg(CFG_SLOPE_START, WORD_W'(ss));
		write_reg(CFG_ANG_MOM, WORD_W'(am));
	endtask

	// One physically sensible run: start, then small steps, mostly forward
	task automatic sensible_run(int steps);
		longint foc;
		foc = rnd_span(32'd1 << 25);
		run_pos = rnd_span(32'd1 << 30);
		send_sample(1'b1, word_t'(run_pos), word_t'(foc));
		repeat (steps) begin
			run_pos = run_pos + longint'($urandom_range(32'd1 << 22, 0));
			if ($urandom_range(15, 0) == 0)
				run_pos = run_pos - longint'($urandom_range(32'd1 << 22, 0));
			if ($urandom_range(3, 0) == 0)
				foc = rnd_span(32'd1 << 25);
			send_sample(1'b0, word_t'(run_pos), word_t'(foc));
		end
	endtask

	// Reset state: steps on a zero beta, then a start with reset registers and steps after it
	task automatic test_reset_state();
		send_sample(1'b0, word_t'(QONE), word_t'(QONE));
		send_sample(1'b0, word_t'(-QONE), '0);
		send_sample(1'b1, '0, word_t'(QONE / 4));
		send_sample(1'b0, word_t'(QONE / 8), word_t'(QONE / 4));
		send_sample(1'b0, word_t'(QONE / 8), word_t'(QONE / 4));
	endtask

	// Extremes of the registers and of the sample fields
	task automatic test_extremes();
		set_config(1, QMIN, QMAX);
		send_sample(1'b1, word_t'(QMIN), word_t'(QMAX));
		send_sample(1'b0, word_t'(QMAX), word_t'(QMIN));
		send_sample(1'b0, word_t'(QMIN), word_t'(QMAX));
		set_config(QMAX >>> 1, QMAX, QMIN);
		send_sample(1'b1, '0, word_t'(QMIN));
		send_sample(1'b0, word_t'(QMAX), word_t'(QMAX));
		send_sample(1'b0, word_t'(-1), word_t'(1));
		// the unused register index must be ignored
		drain();
		write_reg(CFG_ANG_MOM + 2'd1, {WORD_W{1'b1}});
		write_reg(CFG_BETA_START, {WORD_W{1'b1}});
		send_sample(1'b1, word_t'(-1), word_t'(-1));
		send_sample(1'b0, word_t'(QMAX), '0);
		set_config(QONE, 0, QONE);
		send_sample(1'b1, '0, word_t'(QONE / 2));
		send_sample(1'b0, word_t'(QONE / 16), word_t'(QONE / 2));
		send_sample(1'b0, word_t'(QONE / 16), word_t'(QONE / 2));
		send_sample(1'b0, word_t'(QONE / 4), word_t'(QONE / 2));
	endtask

	// Hold the output for a long stretch while samples keep coming
	task automatic test_backpressure();
		drain();
		hold_left = 3000;
		sensible_run(5);
		drain();
	endtask

	// Random runs with varying registers, plus raw noise samples
	task automatic test_random(int total);
		int burst_end;
		burst_end = n_starts + n_steps + 150;
		idle_on = 1'b0;
		while (n_starts + n_steps < total) begin
			if (n_starts + n_steps > burst_end)
				idle_on = 1'b1;
			if ($urandom_range(9, 0) == 0)
				set_config(longint'($urandom_range(32'd1 << 30, 32'd1 << 22)),
					rnd_span(32'd1 << 26), rnd_span(32'd1 << 26));
			if ($urandom_range(4, 0) != 0) begin
				sensible_run($urandom_range(14, 3));
			end else begin
				repeat ($urandom_range(6, 1))
					send_sample($urandom_range(1, 0), rnd_word(), rnd_word());
			end
		end
		idle_on = 1'b1;
		drain();
	endtask

	// Receiver: random stalls, or a long counted hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= idle_on && ($urandom_range(99, 0) < 22);
		end
	end

	// Check each result against the oldest prediction; watch for a hang
	always @(posedge clk) begin
		envelope_t e;
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("beta_envelope_rk4_step test failed");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (envelope_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beta=%h slope=%h fault=%b",
					$time, beta, beta_slope, fault);
			end else begin
				e = envelope_q.pop_front();
				if (e.flt)
					n_faults++;
				if (beta !== word_t'(e.b)) begin
					errors++;
					$display("%0t: beta expected %h got %h", $time, word_t'(e.b), beta);
				end
				if (beta_slope !== word_t'(e.bp)) begin
					errors++;
					$display("%0t: beta_slope expected %h got %h", $time,
						word_t'(e.bp), beta_slope);
				end
				if (fault !== e.flt) begin
					errors++;
					$display("%0t: fault expected %b got %b", $time, e.flt, fault);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		start_req = 1'b0;
		position = '0;
		focusing = '0;
		out_stall = 1'b0;
		errors = 0;
		n_starts = 0;
		n_steps = 0;
		n_faults = 0;
		n_results = 0;
		hold_left = 0;
		quiet_cycles = 0;
		idle_on = 1'b1;
		beta_start_r = QONE;
		slope_start_r = 0;
		ang_mom_r = 0;
		last_pos = 0;
		last_foc = 0;
		beta_cur = 0;
		slope_cur = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_extremes();
		test_backpressure();
		test_random(1700);

		$display("covered %0d start and %0d step samples, %0d results, %0d with fault",
			n_starts, n_steps, n_results, n_faults);
		if (errors == 0 && envelope_q.size() == 0) begin
			$display("beta_envelope_rk4_step test passed");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, envelope_q.size());
			$display("beta_envelope_rk4_step test failed");
		end
		$finish;
	end

endmodule
`default_nettype wire

// File: files.f
hw/rtl/berk4_pkg.sv
hw/rtl/berk4_alu.sv
hw/rtl/beta_envelope_rk4_step.sv
tb/testbench.sv
